// ===== rtl/core/lqhv_pkg.sv =====
// shared constants, types and helpers for the weighted hv interpolator
package lqhv_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int LineRows  = 7;
  localparam int ColW      = 7;
  localparam int RowW      = 7;
  localparam int XW        = $clog2(MaxWidth);
  localparam int LineAddrW = $clog2(LineRows * MaxWidth);
  localparam int DimW      = 7;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);

  // register indexes
  localparam logic [2:0] RegTapsH   = 3'd0;
  localparam logic [2:0] RegTapsV   = 3'd1;
  localparam logic [2:0] RegWeight  = 3'd2;
  localparam logic [2:0] RegOffset  = 3'd3;
  localparam logic [2:0] RegDenom   = 3'd4;
  localparam logic [2:0] RegWidth   = 3'd5;
  localparam logic [2:0] RegHeight  = 3'd6;

  // classified item passed from front to back
  typedef struct packed {
    logic [7:0]    pixel;
    logic          hcalc;
    logic          vcalc;
    logic [XW-1:0] x;
    logic [2:0]    wslot;
    logic [2:0]    rslot;
    logic          row_end;
    logic          block_end;
  } item_t;

  // effective dimension: zero acts as one, clamp to max
  function automatic logic [DimW:0] eff_dim(input logic [DimW-1:0] v,
                                            input logic [DimW:0] mx);
    logic [DimW:0] r;
    begin
      r = {1'b0, v};
      if (v == '0) r = (DimW+1)'(1);
      else if (r > mx) r = mx;
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/lqhv_front.sv =====
// front part: window position tracking and item classification
module lqhv_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [7:0]             pixel_i,
  input  logic                   restart_i,
  input  logic [lqhv_pkg::DimW-1:0] width_i,
  input  logic [lqhv_pkg::DimW-1:0] height_i,
  output lqhv_pkg::item_t        item_o
);

  logic [lqhv_pkg::DimW:0] w, h;
  logic [lqhv_pkg::ColW:0] col_q, col_d;
  logic [lqhv_pkg::RowW:0] row_q, row_d;
  logic [2:0]              wslot_q, wslot_d;
  logic [2:0]              rslot_q, rslot_d;
  logic [lqhv_pkg::ColW:0] x_full;

  assign w = lqhv_pkg::eff_dim(width_i, (lqhv_pkg::DimW+1)'(lqhv_pkg::MaxWidth));
  assign h = lqhv_pkg::eff_dim(height_i, (lqhv_pkg::DimW+1)'(lqhv_pkg::MaxHeight));
  assign x_full = col_q - (lqhv_pkg::ColW+1)'(7);

  // classify the current pixel
  always_comb begin
    item_o.pixel     = pixel_i;
    item_o.hcalc     = (col_q >= 8'd7) && (col_q < 8'(w) + 8'd7) && (row_q < 8'(h) + 8'd7);
    item_o.vcalc     = item_o.hcalc && (row_q >= 8'd7);
    item_o.x         = x_full[lqhv_pkg::XW-1:0];
    item_o.wslot     = wslot_q;
    item_o.rslot     = rslot_q;
    item_o.row_end   = (x_full == 8'(w) - 8'd1);
    item_o.block_end = item_o.row_end && (row_q == 8'(h) + 8'd6);
  end

  // position counters; slot of row r mod 7, read base of row r-7 is also r mod 7
  always_comb begin
    col_d = col_q; row_d = row_q; wslot_d = wslot_q; rslot_d = rslot_q;
    if (restart_i) begin
      col_d = '0; row_d = '0; wslot_d = 3'd0; rslot_d = 3'd0;
    end else if (in_valid_i) begin
      col_d = col_q + 8'd1;
      if (col_d >= 8'(w) + 8'd7) begin
        col_d = '0;
        row_d = row_q + 8'd1;
        wslot_d = (wslot_q == 3'd6) ? 3'd0 : wslot_q + 3'd1;
        rslot_d = (rslot_q == 3'd6) ? 3'd0 : rslot_q + 3'd1;
        if (row_d >= 8'(h) + 8'd7) begin
          row_d = '0; wslot_d = 3'd0; rslot_d = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; wslot_q <= 3'd0; rslot_q <= 3'd0;
    end else begin
      col_q <= col_d; row_q <= row_d; wslot_q <= wslot_d; rslot_q <= rslot_d;
    end
  end

endmodule

// ===== rtl/core/lqhv_back.sv =====
// back part: horizontal filter, line store, vertical filter and weighting
module lqhv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lqhv_pkg::item_t item_i,
  input  logic [63:0]     taps_h_i,
  input  logic [63:0]     taps_v_i,
  input  logic signed [8:0] weight_i,
  input  logic signed [7:0] offset_i,
  input  logic [2:0]      denom_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      pixel_o,
  output logic            row_end_o,
  output logic            block_end_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StHsum  = 4'd1;
  localparam logic [3:0] StRead  = 4'd2;
  localparam logic [3:0] StAcc   = 4'd3;
  localparam logic [3:0] StMul   = 4'd4;
  localparam logic [3:0] StShift = 4'd5;
  localparam logic [3:0] StOut   = 4'd6;

  logic [3:0] state_q, state_d;
  logic [7:0] win_q [8];
  lqhv_pkg::item_t it_q;
  logic [15:0] mem [lqhv_pkg::LineRows * lqhv_pkg::MaxWidth];
  logic [15:0] rd_q;
  logic signed [15:0] hv_q;
  logic [2:0] k_q;
  logic [2:0] slot_q;
  logic signed [26:0] vs_q;
  logic signed [30:0] p_q;
  logic [7:0] res_q;
  logic ob_full_q;
  logic ob_re_q, ob_be_q;
  logic [lqhv_pkg::LineAddrW-1:0] addr;
  logic signed [7:0] vtap;
  logic signed [16:0] hprod;
  logic signed [15:0] hsum;
  logic signed [23:0] vprod;
  logic signed [31:0] rnd;
  logic signed [31:0] sh;
  logic signed [31:0] fin;
  logic take;

  assign take = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  // horizontal 8-tap over the shifted window (narrow, one multiply-tree)
  always_comb begin
    hsum = '0;
    hprod = '0;
    for (int k = 0; k < 7; k++) begin
      hprod = $signed(taps_h_i[8*k +: 8]) * $signed({1'b0, win_q[k]});
      hsum = hsum + hprod[15:0];
    end
    hprod = $signed(taps_h_i[63:56]) * $signed({1'b0, it_q.pixel});
    hsum = hsum + hprod[15:0];
  end

  assign addr = lqhv_pkg::LineAddrW'(slot_q) * lqhv_pkg::LineAddrW'(lqhv_pkg::MaxWidth)
              + lqhv_pkg::LineAddrW'(it_q.x);
  assign vtap = $signed(taps_v_i[8*k_q +: 8]);
  assign vprod = vtap * ((k_q == 3'd7) ? hv_q : $signed(rd_q));

  // rounding shift by denom+6 and offset; the clamp follows in StShift
  always_comb begin
    rnd = 32'(p_q) + (32'sd1 <<< ({1'b0, denom_i} + 4'd5));
    sh  = rnd >>> ({1'b0, denom_i} + 4'd6);
    fin = sh + 32'(offset_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (take) state_d = StHsum;
      StHsum:  state_d = it_q.vcalc ? StRead : (it_q.hcalc ? StOut : StIdle);
      StRead:  state_d = StAcc;
      StAcc:   state_d = (k_q == 3'd7) ? StMul : StRead;
      StMul:   state_d = StShift;
      StShift: state_d = StOut;
      StOut:   if (!ob_full_q || !it_q.vcalc) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ob_full_q <= 1'b0;
      for (int i = 0; i < 8; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) ob_full_q <= 1'b0;
      if (take) begin
        for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
        win_q[7] <= item_i.pixel;
      end
      if (state_q == StOut && it_q.vcalc && !ob_full_q) ob_full_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take) it_q <= item_i;
    case (state_q)
      StHsum: begin
        hv_q <= hsum; k_q <= 3'd0; slot_q <= it_q.rslot; vs_q <= '0;
      end
      StRead: rd_q <= mem[addr];
      StAcc: begin
        vs_q <= vs_q + 27'(vprod);
        k_q <= k_q + 3'd1;
        slot_q <= (slot_q == 3'd6) ? 3'd0 : slot_q + 3'd1;
      end
      StMul: p_q <= 31'(vs_q >>> 6) * 31'(weight_i);
      StShift: res_q <= (fin < 0) ? 8'd0 : ((fin > 255) ? 8'd255 : fin[7:0]);
      StOut: if (!ob_full_q || !it_q.vcalc) begin
        if (it_q.vcalc) begin
          pixel_o <= res_q; ob_re_q <= it_q.row_end; ob_be_q <= it_q.block_end;
        end
      end
      default: ;
    endcase
    if (state_q == StOut && it_q.hcalc && (!ob_full_q || !it_q.vcalc))
      mem[lqhv_pkg::LineAddrW'(it_q.wslot) * lqhv_pkg::LineAddrW'(lqhv_pkg::MaxWidth)
          + lqhv_pkg::LineAddrW'(it_q.x)] <= hv_q;
  end

  assign out_valid_o = ob_full_q;
  assign row_end_o   = ob_re_q;
  assign block_end_o = ob_be_q;

endmodule

// ===== rtl/core/lqhv_queue.sv =====
// short item queue between front and back parts
module lqhv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            flush_i,
  input  logic            push_i,
  input  lqhv_pkg::item_t data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output lqhv_pkg::item_t data_o
);

  lqhv_pkg::item_t buf_q [lqhv_pkg::QDepth];
  logic [lqhv_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [lqhv_pkg::QPtrW:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (lqhv_pkg::QPtrW+1)'(lqhv_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else if (flush_i) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (lqhv_pkg::QPtrW+1)'(do_push) - (lqhv_pkg::QPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wp_q] <= data_i;
  end

endmodule

// ===== rtl/core/luma_qpel_hv_weighted_interp.sv =====
// top level of the weighted 8-tap hv luma interpolator
// Usage: reference pixels of a (W+7)x(H+7) window enter in raster order on
// push/ref_pixel_i while full is low. Prediction pixels leave on
// pred_pixel_o with row_end_o and block_end_o while empty is low; pop
// takes one. A front stage tracks the window position and classifies each
// pixel; a four-entry queue feeds the back end, which runs the filters.
// The back end takes a new pixel only once it is done with the last one:
// a pixel that produces nothing gets only the horizontal sum, a border
// pixel also a line-store write, an output pixel in addition eight line-store
// reads and multiply-accumulates, one weight multiply, a shift, and output.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i apply at once;
// a width or height write restarts the block position.
// Reset clears taps, sets weight 1 and 8x8 geometry, and empties all
// queues; the line store holds no defined values until written.
// When pop stays low, the one-entry output register holds its pixel and
// the back end waits, then the queue fills and full rises.
module luma_qpel_hv_weighted_interp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ref_pixel_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pred_pixel_o,
  output logic        row_end_o,
  output logic        block_end_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] taps_h_q, taps_v_q;
  logic signed [8:0] weight_q;
  logic signed [7:0] offset_q;
  logic [2:0] denom_q;
  logic [6:0] width_q, height_q;
  logic restart;
  logic q_full, q_valid, back_ready, out_valid;
  lqhv_pkg::item_t f_item, q_item;

  assign restart = cfg_we_i &&
    (cfg_idx_i == lqhv_pkg::RegWidth || cfg_idx_i == lqhv_pkg::RegHeight);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_h_q <= '0; taps_v_q <= '0; weight_q <= 9'sd1; offset_q <= '0;
      denom_q <= '0; width_q <= 7'd8; height_q <= 7'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lqhv_pkg::RegTapsH:  taps_h_q <= cfg_data_i;
        lqhv_pkg::RegTapsV:  taps_v_q <= cfg_data_i;
        lqhv_pkg::RegWeight: weight_q <= cfg_data_i[8:0];
        lqhv_pkg::RegOffset: offset_q <= cfg_data_i[7:0];
        lqhv_pkg::RegDenom:  denom_q  <= cfg_data_i[2:0];
        lqhv_pkg::RegWidth:  width_q  <= cfg_data_i[6:0];
        lqhv_pkg::RegHeight: height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign full = q_full;

  lqhv_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push && !q_full), .pixel_i(ref_pixel_i), .restart_i(restart),
    .width_i(width_q), .height_i(height_q), .item_o(f_item)
  );

  lqhv_queue u_queue (
    .clk_i, .rst_ni, .flush_i(1'b0),
    .push_i(push), .data_i(f_item), .full_o(q_full),
    .valid_o(q_valid), .pop_i(back_ready), .data_o(q_item)
  );

  lqhv_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(back_ready), .item_i(q_item),
    .taps_h_i(taps_h_q), .taps_v_i(taps_v_q), .weight_i(weight_q),
    .offset_i(offset_q), .denom_i(denom_q),
    .out_valid_o(out_valid), .out_ready_i(pop),
    .pixel_o(pred_pixel_o), .row_end_o(row_end_o), .block_end_o(block_end_o)
  );

  assign empty = !out_valid;

  // block end only ever comes with row end
  a_blk_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && block_end_o |-> row_end_o) else $error("block end without row end");

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(pred_pixel_o)) else $error("result lost");

  // after taking an item, the back end drops its ready
  a_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_ready && q_valid |=> !back_ready) else $error("back end double take");

endmodule

// ===== tb/sv/luma_qpel_hv_weighted_interp_tb.sv =====
// self-checking testbench for the weighted hv luma interpolator
`timescale 1ns / 100ps

module luma_qpel_hv_weighted_interp_tb;

  localparam logic [2:0]  RegUnused = 3'd7;
  localparam int          HoldOff   = 2000;
  localparam int          DrainWait = 60;
  localparam int          StallMax  = 20000;
  localparam int          RandItems = 300;
  // hevc luma quarter, half and three-quarter phases, full-pel pass-through
  localparam logic [63:0] QpelQ     = 64'h00_01_FB_11_3A_F6_04_FF;
  localparam logic [63:0] QpelH     = 64'hFF_04_F5_28_28_F5_04_FF;
  localparam logic [63:0] Qpel3Q    = 64'hFF_04_F6_3A_11_FB_01_00;
  localparam logic [63:0] FullPel   = 64'h00_00_00_00_40_00_00_00;

  typedef enum int {PixRandom, PixZero, PixMax, PixAlt, PixMixed} pix_mode_e;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       block_end;
  } pred_pix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  ref_pixel_i;
  logic        empty;
  logic        pop;
  logic [7:0]  pred_pixel_o;
  logic        row_end_o;
  logic        block_end_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  // shadow copy of the block state
  logic [63:0] m_taps_h, m_taps_v;
  logic [8:0]  m_weight;
  logic [7:0]  m_offset;
  logic [2:0]  m_denom;
  logic [6:0]  m_width, m_height;
  logic [7:0]  m_window[8];
  logic [15:0] m_lines[7][lqhv_pkg::MaxWidth];
  int          m_col, m_row;

  pred_pix_t   pred_q[$];
  int          err_cnt, item_cnt, pix_cnt, cfg_cnt;
  int          tx_idle_pct, rx_idle_pct, rx_hold;
  int          stall_cnt;

  luma_qpel_hv_weighted_interp u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .ref_pixel_i (ref_pixel_i),
    .empty       (empty),
    .pop         (pop),
    .pred_pixel_o(pred_pixel_o),
    .row_end_o   (row_end_o),
    .block_end_o (block_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always #5 clk_i = ~clk_i;

  function automatic int dim_eff(input logic [6:0] v);
    if (v == 0) return 1;
    return (v > lqhv_pkg::MaxWidth) ? lqhv_pkg::MaxWidth : int'(v);
  endfunction

  function automatic int tap_at(input logic [63:0] packed_taps, input int k);
    logic signed [7:0] t;
    t = packed_taps[8*k +: 8];
    return int'(t);
  endfunction

  // apply a register write to the shadow state
  function automatic void model_write(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      lqhv_pkg::RegTapsH:  m_taps_h = val;
      lqhv_pkg::RegTapsV:  m_taps_v = val;
      lqhv_pkg::RegWeight: m_weight = val[8:0];
      lqhv_pkg::RegOffset: m_offset = val[7:0];
      lqhv_pkg::RegDenom:  m_denom  = val[2:0];
      lqhv_pkg::RegWidth: begin
        m_width = val[6:0];
        m_col = 0;
        m_row = 0;
      end
      lqhv_pkg::RegHeight: begin
        m_height = val[6:0];
        m_col = 0;
        m_row = 0;
      end
      default: ;
    endcase
  endfunction

  // advance the shadow state by one pixel and queue any prediction pixel
  function automatic void interp_pixel(input logic [7:0] p);
    int w, h, x, hs, vs, sh;
    logic [15:0] hv;
    logic signed [15:0] lv;
    longint v, prod, res;
    pred_pix_t e;
    w = dim_eff(m_width);
    h = dim_eff(m_height);
    for (int k = 0; k < 7; k++) m_window[k] = m_window[k+1];
    m_window[7] = p;
    if (m_col >= 7 && m_col < w + 7 && m_row < h + 7) begin
      x = m_col - 7;
      hs = 0;
      for (int k = 0; k < 8; k++) hs += tap_at(m_taps_h, k) * int'({1'b0, m_window[k]});
      hv = hs[15:0];
      if (m_row >= 7) begin
        vs = 0;
        for (int k = 0; k < 7; k++) begin
          lv = m_lines[(m_row + k) % 7][x];
          vs += tap_at(m_taps_v, k) * int'(lv);
        end
        lv = hv;
        vs += tap_at(m_taps_v, 7) * int'(lv);
        v = longint'(vs >>> 6);
        sh = int'(m_denom) + 6;
        prod = v * longint'($signed(m_weight));
        res = ((prod + (64'sd1 <<< (sh - 1))) >>> sh) + longint'($signed(m_offset));
        if (res < 0) res = 0;
        if (res > 255) res = 255;
        e.pixel = res[7:0];
        e.row_end = (x == w - 1);
        e.block_end = (x == w - 1) && (m_row == h + 6);
        pred_q.push_back(e);
      end
      m_lines[m_row % 7][x] = hv;
    end
    m_col++;
    if (m_col >= w + 7) begin
      m_col = 0;
      m_row++;
      if (m_row >= h + 7) m_row = 0;
    end
  endfunction

  // send one item, with random idle cycles in front
  task automatic send_pixel(input logic [7:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    ref_pixel_i <= p;
    do @(posedge clk_i); while (full);
    interp_pixel(p);
    item_cnt++;
  endtask

  // wait until every prediction has arrived and the pipeline has drained
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pred_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    model_write(idx, val);
    cfg_cnt++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [6:0] w, input logic [6:0] h);
    write_reg(lqhv_pkg::RegWidth, 64'(w));
    write_reg(lqhv_pkg::RegHeight, 64'(h));
  endtask

  task automatic set_weighting(input logic [8:0] wt, input logic [7:0] off,
                               input logic [2:0] dn);
    write_reg(lqhv_pkg::RegWeight, 64'(wt));
    write_reg(lqhv_pkg::RegOffset, 64'(off));
    write_reg(lqhv_pkg::RegDenom, 64'(dn));
  endtask

  // send count pixels of the current window, or the whole window when count < 0
  task automatic send_window(input pix_mode_e mode, input int count);
    int n;
    logic [7:0] p;
    n = (count < 0) ? (dim_eff(m_width) + 7) * (dim_eff(m_height) + 7) : count;
    for (int i = 0; i < n; i++) begin
      case (mode)
        PixZero:  p = 8'd0;
        PixMax:   p = 8'd255;
        PixAlt:   p = i[0] ? 8'd255 : 8'd0;
        PixMixed: p = ($urandom_range(3) == 0) ? {8{1'(i[1])}} : 8'($urandom);
        default:  p = 8'($urandom);
      endcase
      send_pixel(p);
    end
  endtask

  function automatic logic [63:0] pick_taps();
    case ($urandom_range(5))
      0: return QpelQ;
      1: return QpelH;
      2: return Qpel3Q;
      3: return FullPel;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result checker and receiver stall control
  initial begin
    pred_pix_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        pix_cnt++;
        if (pred_q.size() == 0) begin
          $display("%0t: unexpected item: pixel %0d row_end %0b block_end %0b",
                   $time, pred_pixel_o, row_end_o, block_end_o);
          err_cnt++;
        end else begin
          e = pred_q.pop_front();
          if (pred_pixel_o !== e.pixel) begin
            $display("%0t: pred_pixel expected %0d actual %0d", $time, e.pixel, pred_pixel_o);
            err_cnt++;
          end
          if (row_end_o !== e.row_end) begin
            $display("%0t: row_end expected %0b actual %0b", $time, e.row_end, row_end_o);
            err_cnt++;
          end
          if (block_end_o !== e.block_end) begin
            $display("%0t: block_end expected %0b actual %0b",
                     $time, e.block_end, block_end_o);
            err_cnt++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallMax) begin
      $display("%0t: timeout, %0d predictions outstanding", $time, pred_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // reset values, then the first output row of a default-config window
  task automatic test_reset_defaults();
    m_taps_h = '0;
    m_taps_v = '0;
    m_weight = 9'd1;
    m_offset = '0;
    m_denom = '0;
    m_width = 7'd8;
    m_height = 7'd8;
    m_col = 0;
    m_row = 0;
    for (int k = 0; k < 8; k++) m_window[k] = '0;
    send_window(PixRandom, 120);
    wait_idle();
  endtask

  // field extremes, weighting extremes and geometry corner cases
  task automatic test_directed();
    write_reg(lqhv_pkg::RegTapsH, QpelH);
    write_reg(lqhv_pkg::RegTapsV, QpelH);
    set_weighting(9'd255, 8'sd127, 3'd0);
    set_geometry(7'd8, 7'd1);
    send_window(PixMax, -1);
    wait_idle();
    set_weighting(9'h180, 8'h80, 3'd7);
    send_window(PixAlt, -1);
    wait_idle();
    // most negative and most positive taps wrap the horizontal sum
    write_reg(lqhv_pkg::RegTapsH, 64'h8080_8080_7F7F_7F7F);
    write_reg(lqhv_pkg::RegTapsV, 64'h7F80_7F80_7F80_7F80);
    set_weighting(9'd1, 8'd0, 3'd0);
    send_window(PixMixed, -1);
    wait_idle();
    // zero geometry acts as 1x1, with all-max taps against all-min taps
    write_reg(lqhv_pkg::RegTapsH, 64'h7F7F_7F7F_7F7F_7F7F);
    write_reg(lqhv_pkg::RegTapsV, 64'h8080_8080_8080_8080);
    set_weighting(9'd64, 8'sd5, 3'd6);
    set_geometry(7'd0, 7'd0);
    send_window(PixMax, -1);
    wait_idle();
    // unaligned geometry
    write_reg(lqhv_pkg::RegTapsH, QpelQ);
    write_reg(lqhv_pkg::RegTapsV, Qpel3Q);
    set_geometry(7'd13, 7'd3);
    send_window(PixRandom, -1);
    wait_idle();
    // index past the register list leaves everything alone
    write_reg(RegUnused, {$urandom, $urandom});
    set_geometry(7'd8, 7'd1);
    send_window(PixRandom, 40);
    wait_idle();
    // geometry write after a cut-short window restarts the block
    set_geometry(7'd9, 7'd1);
    send_window(PixRandom, -1);
    wait_idle();
  endtask

  // random configuration per window, most windows complete, some cut short
  task automatic test_random();
    int sent_from;
    logic [6:0] w, h;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 69;
        end
        1: begin
          tx_idle_pct = 69;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent_from = item_cnt;
      while (item_cnt - sent_from < RandItems / 3) begin
        write_reg(lqhv_pkg::RegTapsH, pick_taps());
        write_reg(lqhv_pkg::RegTapsV, pick_taps());
        set_weighting(9'($urandom_range(383) - 128), 8'($urandom), 3'($urandom));
        case ($urandom_range(9))
          0: w = 7'd0;
          1: w = 7'd64;
          2: w = 7'($urandom_range(20, 1));
          3: w = 7'd16;
          default: w = 7'd8;
        endcase
        h = (w == 7'd64) ? 7'd0 : 7'($urandom_range(2));
        set_geometry(w, h);
        if ($urandom_range(7) == 0) send_window(PixMixed, $urandom_range(60, 1));
        else send_window(($urandom_range(3) == 0) ? PixMixed : PixRandom, -1);
        wait_idle();
      end
    end
  endtask

  // long receiver hold-off while the sender keeps pushing; oversized width
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(lqhv_pkg::RegTapsH, QpelQ);
    write_reg(lqhv_pkg::RegTapsV, QpelH);
    set_weighting(9'd96, 8'hF0, 3'd5);
    set_geometry(7'd127, 7'd1);
    rx_hold = HoldOff;
    send_window(PixRandom, -1);
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    ref_pixel_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    err_cnt = 0;
    item_cnt = 0;
    pix_cnt = 0;
    cfg_cnt = 0;
    stall_cnt = 0;
    rx_hold = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random();
    wait_idle();
    $display("run covered %0d reference pixels, %0d prediction pixels, %0d register writes",
             item_cnt, pix_cnt, cfg_cnt);
    $display("with corner taps and weights, odd and clamped geometry, stalls on both sides");
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lqhv_pkg.sv
rtl/core/lqhv_front.sv
rtl/core/lqhv_back.sv
rtl/core/lqhv_queue.sv
rtl/core/luma_qpel_hv_weighted_interp.sv
tb/sv/luma_qpel_hv_weighted_interp_tb.sv
